// ===== sv/spa_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helper functions of the solar position pipeline
package spa_pkg;

    // angle output resolution and cordic shape
    localparam int ANGLE_BITS_DEF = 24;
    localparam int CORDIC_STEPS   = 28;
    localparam int CW             = 34;

    // one cordic lane between two cells
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cordic_t;

    // arctangent of 2^-i in 2^-32 turn
    localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81,
        34'sd41,        34'sd20,        34'sd10,        34'sd5
    };

    localparam logic signed [CW-1:0] KINV      = 34'sd652032874;
    localparam logic signed [CW-1:0] QUARTER   = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN = 34'sd2147483648;

    // epoch in 2^-16 day
    localparam logic signed [40:0] EPOCH_FX = 41'sd160664453120;

    // mean longitude, anomaly and obliquity: offsets in 2^-64 turn
    localparam logic [127:0] L_OFS_W = (128'd280460 << 64) / 128'd360000;
    localparam logic [127:0] G_OFS_W = (128'd357528 << 64) / 128'd360000;
    localparam logic [127:0] E_OFS_W = (128'd23439 << 64) / 128'd360000;
    localparam logic [63:0]  L_OFS   = L_OFS_W[63:0];
    localparam logic [63:0]  G_OFS   = G_OFS_W[63:0];
    localparam logic [63:0]  E_OFS   = E_OFS_W[63:0];

    // rates in 2^-64 turn per 2^-16 day
    localparam logic [127:0] L_RATE_W = (128'd9856474 << 48) / 128'd3600000000;
    localparam logic [127:0] G_RATE_W = (128'd9856003 << 48) / 128'd3600000000;
    localparam logic [127:0] E_RATE_W = (128'd4 << 48) / 128'd3600000000;
    localparam logic [39:0]  RATES [3] = '{L_RATE_W[39:0], G_RATE_W[39:0], E_RATE_W[39:0]};

    // equation of centre and distance coefficients
    localparam logic [127:0] C1915_W = (128'd1915 << 32) / 128'd360000;
    localparam logic [127:0] C20_W   = (128'd20 << 32) / 128'd360000;
    localparam logic [127:0] C1671_W = (128'd1671 << 30) / 128'd100000;
    localparam logic [127:0] C14_W   = (128'd14 << 30) / 128'd100000;
    localparam logic [127:0] R0_W    = (128'd100014 << 30) / 128'd100000;
    localparam logic signed [31:0] C1915 = signed'(C1915_W[31:0]);
    localparam logic signed [31:0] C20   = signed'(C20_W[31:0]);
    localparam logic signed [31:0] C1671 = signed'(C1671_W[31:0]);
    localparam logic signed [31:0] C14   = signed'(C14_W[31:0]);
    localparam logic signed [39:0] R0    = signed'(R0_W[39:0]);
    localparam logic signed [39:0] DIST_MAX = 40'sd131071;

    // fold an angle into plus or minus a quarter turn for rotation
    function automatic cordic_t rot_prefold(input logic [31:0] a);
        cordic_t r;
        logic signed [CW-1:0] z;
        z = CW'(signed'(a));
        r.flip = 1'b0;
        if (z > QUARTER) begin
            z = z - HALF_TURN;
            r.flip = 1'b1;
        end else if (z < -QUARTER) begin
            z = z + HALF_TURN;
            r.flip = 1'b1;
        end
        r.x = KINV;
        r.y = '0;
        r.z = z;
        return r;
    endfunction

    // bring the vector into the right half plane for vectoring
    function automatic cordic_t vec_prefold(input logic signed [CW-1:0] x,
                                            input logic signed [CW-1:0] y);
        cordic_t r;
        r.flip = 1'b0;
        if (x < 0) begin
            r.x = -x;
            r.y = -y;
            r.z = HALF_TURN;
        end else begin
            r.x = x;
            r.y = y;
            r.z = '0;
        end
        return r;
    endfunction

    // cosine and sine after a rotation lane
    function automatic logic signed [31:0] rot_cos(input cordic_t r);
        logic signed [CW-1:0] v;
        v = r.flip ? -r.x : r.x;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] rot_sin(input cordic_t r);
        logic signed [CW-1:0] v;
        v = r.flip ? -r.y : r.y;
        return v[31:0];
    endfunction

endpackage

// ===== sv/spa_rot_cell.sv =====
`timescale 1ns / 1ps
// one cordic rotation step as a registered cell
module spa_rot_cell #(
    parameter int STEP = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  spa_pkg::cordic_t d_in,
    output spa_pkg::cordic_t d_out
);

    spa_pkg::cordic_t cell_reg;
    spa_pkg::cordic_t cell_next;

    // rotate toward zero residual angle
    always_comb begin
        cell_next = d_in;
        if (d_in.z >= 0) begin
            cell_next.x = d_in.x - (d_in.y >>> STEP);
            cell_next.y = d_in.y + (d_in.x >>> STEP);
            cell_next.z = d_in.z - spa_pkg::ATAN_TURNS[STEP];
        end else begin
            cell_next.x = d_in.x + (d_in.y >>> STEP);
            cell_next.y = d_in.y - (d_in.x >>> STEP);
            cell_next.z = d_in.z + spa_pkg::ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

// ===== sv/spa_vec_cell.sv =====
`timescale 1ns / 1ps
// one cordic vectoring step as a registered cell
module spa_vec_cell #(
    parameter int STEP = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  spa_pkg::cordic_t d_in,
    output spa_pkg::cordic_t d_out
);

    spa_pkg::cordic_t cell_reg;
    spa_pkg::cordic_t cell_next;

    // drive y toward zero and accumulate the angle
    always_comb begin
        cell_next = d_in;
        if (d_in.y >= 0) begin
            cell_next.x = d_in.x + (d_in.y >>> STEP);
            cell_next.y = d_in.y - (d_in.x >>> STEP);
            cell_next.z = d_in.z + spa_pkg::ATAN_TURNS[STEP];
        end else begin
            cell_next.x = d_in.x - (d_in.y >>> STEP);
            cell_next.y = d_in.y + (d_in.x >>> STEP);
            cell_next.z = d_in.z - spa_pkg::ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign d_out = cell_reg;

endmodule

// ===== sv/spa_front.sv =====
`timescale 1ns / 1ps
// day offset and mean angles: three pipeline stages
module spa_front (
    input  logic        aclk,
    input  logic [2:0]  en,
    input  logic [39:0] julian_day,
    output logic [31:0] l_ang,
    output logic [31:0] g_ang,
    output logic [31:0] e_ang
);

    logic signed [40:0] n_reg;
    logic [43:0]        pll_reg [3];
    logic [43:0]        plh_reg [3];
    logic signed [37:0] phl_reg [3];
    logic signed [37:0] phh_reg [3];
    logic [63:0]        prod    [3];
    logic [31:0]        l_reg, g_reg, e_reg;
    logic [23:0]        n_lo;
    logic signed [16:0] n_hi;

    assign n_lo = n_reg[23:0];
    assign n_hi = n_reg[40:24];

    // offset from the epoch
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            n_reg <= signed'({1'b0, julian_day}) - spa_pkg::EPOCH_FX;
        end
    end

    // partial products of offset and rate
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int j = 0; j < 3; j++) begin
                pll_reg[j] <= n_lo * spa_pkg::RATES[j][19:0];
                plh_reg[j] <= n_lo * spa_pkg::RATES[j][39:20];
                phl_reg[j] <= n_hi * signed'({1'b0, spa_pkg::RATES[j][19:0]});
                phh_reg[j] <= n_hi * signed'({1'b0, spa_pkg::RATES[j][39:20]});
            end
        end
    end

    // recombine modulo one turn
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            prod[j] = {20'b0, pll_reg[j]} + ({20'b0, plh_reg[j]} << 20)
                    + ({{26{phl_reg[j][37]}}, phl_reg[j]} << 24)
                    + ({{26{phh_reg[j][37]}}, phh_reg[j]} << 44);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            l_reg <= 32'((spa_pkg::L_OFS + prod[0]) >> 32);
            g_reg <= 32'((spa_pkg::G_OFS + prod[1]) >> 32);
            e_reg <= 32'((spa_pkg::E_OFS - prod[2]) >> 32);
        end
    end

    assign l_ang = l_reg;
    assign g_ang = g_reg;
    assign e_ang = e_reg;

endmodule

// ===== sv/solar_position_unit.sv =====
`timescale 1ns / 1ps
// top level: low precision apparent solar position pipeline
//
// Input channel s_: one item is a Julian day in 2^-16 day (s_julian_day).
// Result channel m_: right ascension and declination in 2^-ANGLE_BITS turn,
// earth-sun distance in 2^-16 AU. Every item gives exactly one result.
// The datapath is a chain of 124 register stages: the mean angle front end,
// four rows of 28 cordic cells (rotation of anomaly, double anomaly and
// obliquity in parallel, rotation of ecliptic longitude, vectoring for right
// ascension, vectoring for declination) and prefold, multiply, sum and output stages around them.
// One item is taken per cycle while s_ready is high.
// Each stage has a valid bit and moves on when its successor is empty or
// moving, so a stalled receiver only halts the chain once it is full and
// empty stages still take new items. Synchronous reset on aresetn clears all
// valid bits; the pipeline is empty afterwards, with nothing to sweep.
module solar_position_unit #(
    parameter int ANGLE_BITS = spa_pkg::ANGLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [39:0]        s_julian_day,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_right_ascension,
    output logic signed [23:0] m_declination,
    output logic [16:0]        m_distance_au
);

    localparam int NS     = spa_pkg::CORDIC_STEPS;
    localparam int CW     = spa_pkg::CW;
    localparam int SH     = 32 - ANGLE_BITS;
    localparam int K_ANG  = 2;
    localparam int K_PRE1 = 3;
    localparam int K_MUL1 = K_PRE1 + NS + 1;
    localparam int K_LAM  = K_MUL1 + 1;
    localparam int K_PRE2 = K_LAM + 1;
    localparam int K_MUL2 = K_PRE2 + NS + 1;
    localparam int K_PRE3 = K_MUL2 + 1;
    localparam int K_MUL3 = K_PRE3 + NS + 1;
    localparam int K_PRE4 = K_MUL3 + 1;
    localparam int K_OUT  = K_PRE4 + NS + 1;
    localparam int D      = K_OUT + 1;
    localparam int NL     = K_MUL1 - K_PRE1 + 1;
    localparam int NC     = K_MUL2 - K_LAM;
    localparam int NY     = K_MUL3 - K_PRE3;
    localparam int NR     = K_OUT - K_PRE4;
    localparam int NDS    = K_OUT - K_LAM;

    logic [D-1:0] v_reg;
    logic [D:0]   adv;

    // stage valid chain with bubble collapse
    always_comb begin
        adv[D] = m_ready;
        for (int k = D - 1; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < D; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_ready = adv[0];
    assign m_valid = v_reg[K_OUT];

    // mean angles
    logic [31:0] l_ang, g_ang, e_ang;

    spa_front u_front (
        .aclk       (aclk),
        .en         (adv[K_ANG:0]),
        .julian_day (s_julian_day),
        .l_ang      (l_ang),
        .g_ang      (g_ang),
        .e_ang      (e_ang)
    );

    // first rotation row: anomaly, double anomaly, obliquity
    spa_pkg::cordic_t g_ch [NS+1];
    spa_pkg::cordic_t g2_ch[NS+1];
    spa_pkg::cordic_t e_ch [NS+1];
    spa_pkg::cordic_t g_pre_reg, g2_pre_reg, e_pre_reg;
    logic [31:0]      l_pipe [NL];

    always_ff @(posedge aclk) begin
        if (adv[K_PRE1]) begin
            g_pre_reg  <= spa_pkg::rot_prefold(g_ang);
            g2_pre_reg <= spa_pkg::rot_prefold({g_ang[30:0], 1'b0});
            e_pre_reg  <= spa_pkg::rot_prefold(e_ang);
            l_pipe[0]  <= l_ang;
        end
        for (int j = 1; j < NL; j++) begin
            if (adv[K_PRE1+j]) begin
                l_pipe[j] <= l_pipe[j-1];
            end
        end
    end

    assign g_ch[0]  = g_pre_reg;
    assign g2_ch[0] = g2_pre_reg;
    assign e_ch[0]  = e_pre_reg;

    for (genvar i = 0; i < NS; i++) begin : g_row1
        spa_rot_cell #(.STEP(i)) u_g (
            .aclk (aclk), .en (adv[K_PRE1+1+i]), .d_in (g_ch[i]), .d_out (g_ch[i+1]));
        spa_rot_cell #(.STEP(i)) u_g2 (
            .aclk (aclk), .en (adv[K_PRE1+1+i]), .d_in (g2_ch[i]), .d_out (g2_ch[i+1]));
        spa_rot_cell #(.STEP(i)) u_e (
            .aclk (aclk), .en (adv[K_PRE1+1+i]), .d_in (e_ch[i]), .d_out (e_ch[i+1]));
    end

    // equation of centre and distance products
    logic signed [63:0] p1_reg, p2_reg, q1_reg, q2_reg;
    logic signed [31:0] ce_m1_reg, se_m1_reg;

    always_ff @(posedge aclk) begin
        if (adv[K_MUL1]) begin
            p1_reg    <= spa_pkg::rot_sin(g_ch[NS]) * spa_pkg::C1915;
            p2_reg    <= spa_pkg::rot_sin(g2_ch[NS]) * spa_pkg::C20;
            q1_reg    <= spa_pkg::rot_cos(g_ch[NS]) * spa_pkg::C1671;
            q2_reg    <= spa_pkg::rot_cos(g2_ch[NS]) * spa_pkg::C14;
            ce_m1_reg <= spa_pkg::rot_cos(e_ch[NS]);
            se_m1_reg <= spa_pkg::rot_sin(e_ch[NS]);
        end
    end

    // ecliptic longitude and clipped distance
    logic signed [63:0] p1_sh, p2_sh, q1_sh, q2_sh;
    logic signed [39:0] r30, d40;
    logic [16:0]        dist_clip;
    logic [31:0]        lam_reg;
    logic signed [31:0] ce_pipe [NC];
    logic signed [31:0] se_pipe [NC];
    logic [16:0]        dist_pipe [NDS];

    always_comb begin
        p1_sh = p1_reg >>> 30;
        p2_sh = p2_reg >>> 30;
        q1_sh = q1_reg >>> 30;
        q2_sh = q2_reg >>> 30;
        r30   = spa_pkg::R0 - q1_sh[39:0] - q2_sh[39:0];
        d40   = r30 >>> 14;
        if (d40 < 0) begin
            dist_clip = '0;
        end else if (d40 > spa_pkg::DIST_MAX) begin
            dist_clip = spa_pkg::DIST_MAX[16:0];
        end else begin
            dist_clip = d40[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[K_LAM]) begin
            lam_reg      <= l_pipe[NL-1] + p1_sh[31:0] + p2_sh[31:0];
            ce_pipe[0]   <= ce_m1_reg;
            se_pipe[0]   <= se_m1_reg;
            dist_pipe[0] <= dist_clip;
        end
        for (int j = 1; j < NC; j++) begin
            if (adv[K_LAM+j]) begin
                ce_pipe[j] <= ce_pipe[j-1];
                se_pipe[j] <= se_pipe[j-1];
            end
        end
        for (int j = 1; j < NDS; j++) begin
            if (adv[K_LAM+j]) begin
                dist_pipe[j] <= dist_pipe[j-1];
            end
        end
    end

    // second rotation row: ecliptic longitude
    spa_pkg::cordic_t lam_ch [NS+1];
    spa_pkg::cordic_t lam_pre_reg;

    always_ff @(posedge aclk) begin
        if (adv[K_PRE2]) begin
            lam_pre_reg <= spa_pkg::rot_prefold(lam_reg);
        end
    end

    assign lam_ch[0] = lam_pre_reg;

    for (genvar i = 0; i < NS; i++) begin : g_row2
        spa_rot_cell #(.STEP(i)) u_lam (
            .aclk (aclk), .en (adv[K_PRE2+1+i]), .d_in (lam_ch[i]), .d_out (lam_ch[i+1]));
    end

    // equatorial products
    logic signed [31:0] cl_reg;
    logic signed [63:0] ys_reg, yd_reg;

    always_ff @(posedge aclk) begin
        if (adv[K_MUL2]) begin
            cl_reg <= spa_pkg::rot_cos(lam_ch[NS]);
            ys_reg <= ce_pipe[NC-1] * spa_pkg::rot_sin(lam_ch[NS]);
            yd_reg <= se_pipe[NC-1] * spa_pkg::rot_sin(lam_ch[NS]);
        end
    end

    // right ascension vectoring row
    logic signed [63:0]   ys_sh, yd_sh;
    logic signed [CW-1:0] yd_pipe [NY];
    spa_pkg::cordic_t     ra_ch [NS+1];
    spa_pkg::cordic_t     ra_pre_reg;

    assign ys_sh = ys_reg >>> 30;
    assign yd_sh = yd_reg >>> 30;

    always_ff @(posedge aclk) begin
        if (adv[K_PRE3]) begin
            ra_pre_reg <= spa_pkg::vec_prefold(CW'(cl_reg), ys_sh[CW-1:0]);
            yd_pipe[0] <= yd_sh[CW-1:0];
        end
        for (int j = 1; j < NY; j++) begin
            if (adv[K_PRE3+j]) begin
                yd_pipe[j] <= yd_pipe[j-1];
            end
        end
    end

    assign ra_ch[0] = ra_pre_reg;

    for (genvar i = 0; i < NS; i++) begin : g_row3
        spa_vec_cell #(.STEP(i)) u_ra (
            .aclk (aclk), .en (adv[K_PRE3+1+i]), .d_in (ra_ch[i]), .d_out (ra_ch[i+1]));
    end

    // gain correction of the magnitude
    logic signed [63:0]   mk_reg;
    logic signed [CW-1:0] yd3_reg;
    logic [31:0]          ra_m3_reg;

    always_ff @(posedge aclk) begin
        if (adv[K_MUL3]) begin
            mk_reg    <= ra_ch[NS].x[31:0] * spa_pkg::KINV[31:0];
            yd3_reg   <= yd_pipe[NY-1];
            ra_m3_reg <= ra_ch[NS].z[31:0];
        end
    end

    // declination vectoring row
    logic signed [63:0] mk_sh;
    logic [31:0]        ra_pipe [NR];
    spa_pkg::cordic_t   dec_ch [NS+1];
    spa_pkg::cordic_t   dec_pre_reg;

    assign mk_sh = mk_reg >>> 30;

    always_ff @(posedge aclk) begin
        if (adv[K_PRE4]) begin
            dec_pre_reg <= spa_pkg::vec_prefold(mk_sh[CW-1:0], yd3_reg);
            ra_pipe[0]  <= ra_m3_reg;
        end
        for (int j = 1; j < NR; j++) begin
            if (adv[K_PRE4+j]) begin
                ra_pipe[j] <= ra_pipe[j-1];
            end
        end
    end

    assign dec_ch[0] = dec_pre_reg;

    for (genvar i = 0; i < NS; i++) begin : g_row4
        spa_vec_cell #(.STEP(i)) u_dec (
            .aclk (aclk), .en (adv[K_PRE4+1+i]), .d_in (dec_ch[i]), .d_out (dec_ch[i+1]));
    end

    // output register
    logic [31:0]        ra_shift;
    logic signed [63:0] dec_shift;
    logic [23:0]        ra_out_reg;
    logic signed [23:0] dec_out_reg;
    logic [16:0]        dist_out_reg;

    assign ra_shift  = ra_pipe[NR-1] >> SH;
    assign dec_shift = 64'(dec_ch[NS].z) >>> SH;

    always_ff @(posedge aclk) begin
        if (adv[K_OUT]) begin
            ra_out_reg   <= ra_shift[23:0];
            dec_out_reg  <= dec_shift[23:0];
            dist_out_reg <= dist_pipe[NDS-1];
        end
    end

    assign m_right_ascension = ra_out_reg;
    assign m_declination     = dec_out_reg;
    assign m_distance_au     = dist_out_reg;

    // an empty or draining output stage lets the whole chain move
    a_ready_when_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input blocked while output stage drains");

    // a stalled result holds back the output stage
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !adv[K_OUT])
        else $error("output stage advanced under stall");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result present after reset");

    // distance stays near one astronomical unit
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_distance_au > 17'd60000 && m_distance_au < 17'd70000))
        else $error("distance out of physical range");

endmodule
